// ===== rtl/feg_pkg.sv =====
// feg_pkg: shared constants, codes and types for the fade envelope generator
// no dependencies; imported by feg_div and fade_envelope_generator_top

package feg_pkg;

  // default sizes
  localparam int TIME_BITS_DEF       = 24;
  localparam int ALPHA_FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int DELTA_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int PHASE_BITS    = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_IN_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_OUT_LIMIT = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_ENABLE    = 2'd3;

  // reported phase codes
  localparam logic [PHASE_BITS-1:0] PHASE_FADE_IN  = 2'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_HOLD     = 2'd1;
  localparam logic [PHASE_BITS-1:0] PHASE_FADE_OUT = 2'd2;
  localparam logic [PHASE_BITS-1:0] PHASE_END      = 2'd3;

  // status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } feg_div_stat_t;

endpackage

// ===== rtl/feg_div.sv =====
// feg_div: restoring divider giving floor(dividend * 2^FRAC_BITS / divisor)
// for dividend < divisor, one quotient bit per cycle; uses feg_pkg

module feg_div import feg_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [TIME_BITS-1:0] divisor,
  output logic [FRAC_BITS-1:0] quotient,
  output feg_div_stat_t        stat
);

  localparam int CNT_BITS = $clog2(FRAC_BITS);

  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [TIME_BITS:0]   rem2;
  logic [TIME_BITS:0]   diff;
  logic                 ge;
  logic                 last;

  // one shift, compare and subtract step
  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, divisor};
  assign ge   = (rem2 >= {1'b0, divisor});
  assign last = (cnt_r == CNT_BITS'(FRAC_BITS - 1));

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[TIME_BITS-1:0] : rem2[TIME_BITS-1:0];
      quo_nxt = {quo_r[FRAC_BITS-2:0], ge};
      cnt_nxt = cnt_r + CNT_BITS'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < divisor))
    else $error("partial remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("done without a finished division");

endmodule

// ===== rtl/fade_envelope_generator_top.sv =====
// fade_envelope_generator_top: trapezoidal fade-in / hold / fade-out envelope
// uses feg_pkg and the shared serial divider feg_div
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in_     | in        | in_valid/in_stall  | in_time_delta[15:0]
//   out_    | out       | out_valid/out_stall| out_alpha, out_phase, out_finished
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index[1:0], cfg_data[23:0]
//
// a request during a ramp passes the add, compare, divider wait and output states, the
// divider giving one quotient bit a cycle; in hold or on a phase end it skips the wait,
// in a stalled phase or after the end also the compare; the next request can be taken
// in the cycle after the result is loaded
// in_stall stays high from acceptance until the result is loaded into the output
// register; a result held by out_stall does not block the next request's work
// synchronous active-low reset; envelope state returns to fade-in at full alpha
// cfg_ready is always high; the user must write registers only while the block is idle, the block does not enforce it

module fade_envelope_generator_top import feg_pkg::*; #(
  parameter int TIME_BITS       = TIME_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // tick requests
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [DELTA_BITS-1:0]    in_time_delta,
  // results
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ALPHA_FRAC_BITS:0] out_alpha,
  output logic [PHASE_BITS-1:0]    out_phase,
  output logic                     out_finished,
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int ELAP_BITS  = TIME_BITS + 1;
  localparam int WIDE_BITS  = (ELAP_BITS > DELTA_BITS) ? ELAP_BITS : DELTA_BITS;
  localparam int SUM_BITS   = WIDE_BITS + 1;
  localparam int ALPHA_BITS = ALPHA_FRAC_BITS + 1;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // which phase is being advanced
  localparam logic [1:0] BR_IN   = 2'd0;
  localparam logic [1:0] BR_HOLD = 2'd1;
  localparam logic [1:0] BR_OUT  = 2'd2;

  // configuration registers
  logic [TIME_BITS-1:0] fade_in_limit_r, hold_limit_r, fade_out_limit_r;
  logic                 loop_enable_r;
  logic [TIME_BITS+CFG_DATA_BITS-1:0] cfg_wide;
  logic [TIME_BITS-1:0] cfg_limit;

  // envelope state
  logic                  fade_in_done_r, fade_in_done_nxt;
  logic                  hold_done_r, hold_done_nxt;
  logic                  ended_r, ended_nxt;
  logic [ELAP_BITS-1:0]  elapsed_r, elapsed_nxt;
  logic [ALPHA_BITS-1:0] alpha_value_r, alpha_value_nxt;

  // sequencer
  logic [2:0]            st_r, st_nxt;
  logic [1:0]            branch_r, branch_nxt;
  logic [DELTA_BITS-1:0] delta_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [ALPHA_BITS-1:0] out_alpha_r;
  logic [PHASE_BITS-1:0] out_phase_r;
  logic                  out_finished_r;
  logic                  out_load;

  // datapath helpers
  logic [SUM_BITS-1:0]        sum;
  logic [TIME_BITS-1:0]       limit_sel;
  logic                       reached;
  logic                       div_start;
  logic [ALPHA_FRAC_BITS-1:0] div_quo;
  feg_div_stat_t              div_stat;
  logic                       in_accept;

  assign in_accept = in_valid && (st_r == ST_IDLE);
  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // limits use the low TIME_BITS of the written data, zero-extended if wider
  assign cfg_wide  = {{TIME_BITS{1'b0}}, cfg_data};
  assign cfg_limit = cfg_wide[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_in_limit_r  <= '0;
      hold_limit_r     <= '0;
      fade_out_limit_r <= '0;
      loop_enable_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FADE_IN_LIMIT:  fade_in_limit_r  <= cfg_limit;
        CFG_HOLD_LIMIT:     hold_limit_r     <= cfg_limit;
        CFG_FADE_OUT_LIMIT: fade_out_limit_r <= cfg_limit;
        CFG_LOOP_ENABLE:    loop_enable_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturating time accumulation
  assign sum = SUM_BITS'(elapsed_r) + SUM_BITS'(delta_r);

  // limit of the phase in progress
  always_comb begin
    case (branch_r)
      BR_IN:   limit_sel = fade_in_limit_r;
      BR_HOLD: limit_sel = hold_limit_r;
      BR_OUT:  limit_sel = fade_out_limit_r;
      default: limit_sel = fade_out_limit_r;
    endcase
  end

  assign reached = (elapsed_r >= {1'b0, limit_sel});

  always_comb begin
    st_nxt           = st_r;
    branch_nxt       = branch_r;
    fade_in_done_nxt = fade_in_done_r;
    hold_done_nxt    = hold_done_r;
    ended_nxt        = ended_r;
    elapsed_nxt      = elapsed_r;
    alpha_value_nxt  = alpha_value_r;
    div_start        = 1'b0;
    out_load         = 1'b0;
    out_valid_nxt    = out_valid_r && out_stall;

    case (st_r)
      ST_IDLE: begin
        if (in_accept) begin
          st_nxt = ST_ADD;
        end
      end

      // pick the active phase and add the time step
      ST_ADD: begin
        st_nxt = ST_CMP;
        if (ended_r) begin
          alpha_value_nxt = '0;
          st_nxt          = ST_OUT;
        end else if (fade_in_limit_r != '0 && !fade_in_done_r) begin
          branch_nxt = BR_IN;
        end else if (hold_limit_r != '0 && fade_in_done_r && !hold_done_r) begin
          branch_nxt = BR_HOLD;
        end else if (fade_out_limit_r != '0 && hold_done_r) begin
          branch_nxt = BR_OUT;
        end else begin
          // zero limit: envelope waits, alpha unchanged
          st_nxt = ST_OUT;
        end
        if (st_nxt == ST_CMP) begin
          if (sum > SUM_BITS'({ELAP_BITS{1'b1}})) begin
            elapsed_nxt = '1;
          end else begin
            elapsed_nxt = sum[ELAP_BITS-1:0];
          end
        end
      end

      // phase end check, otherwise start the ramp division in a fade-in or fade-out
      ST_CMP: begin
        st_nxt = ST_OUT;
        case (branch_r)
          BR_HOLD: begin
            alpha_value_nxt = ALPHA_ONE;
            if (reached) begin
              hold_done_nxt = 1'b1;
              elapsed_nxt   = '0;
            end
          end
          BR_IN: begin
            if (reached) begin
              alpha_value_nxt  = ALPHA_ONE;
              fade_in_done_nxt = 1'b1;
              elapsed_nxt      = '0;
            end else begin
              div_start = 1'b1;
              st_nxt    = ST_WAIT;
            end
          end
          default: begin
            if (reached) begin
              alpha_value_nxt = '0;
              elapsed_nxt     = '0;
              if (loop_enable_r) begin
                fade_in_done_nxt = 1'b0;
                hold_done_nxt    = 1'b0;
              end else begin
                ended_nxt = 1'b1;
              end
            end else begin
              div_start = 1'b1;
              st_nxt    = ST_WAIT;
            end
          end
        endcase
      end

      ST_WAIT: begin
        if (div_stat.done) begin
          if (branch_r == BR_IN) begin
            alpha_value_nxt = {1'b0, div_quo};
          end else begin
            alpha_value_nxt = ALPHA_ONE - {1'b0, div_quo};
          end
          st_nxt = ST_OUT;
        end
      end

      // hand the result over once the output register is free
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      delta_r <= in_time_delta;
    end
    if (out_load) begin
      out_alpha_r    <= alpha_value_r;
      out_finished_r <= ended_r;
      if (ended_r) begin
        out_phase_r <= PHASE_END;
      end else if (!fade_in_done_r) begin
        out_phase_r <= PHASE_FADE_IN;
      end else if (!hold_done_r) begin
        out_phase_r <= PHASE_HOLD;
      end else begin
        out_phase_r <= PHASE_FADE_OUT;
      end
    end
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      branch_r       <= BR_IN;
      fade_in_done_r <= 1'b0;
      hold_done_r    <= 1'b0;
      ended_r        <= 1'b0;
      elapsed_r      <= '0;
      alpha_value_r  <= ALPHA_ONE;
      out_valid_r    <= 1'b0;
    end else begin
      st_r           <= st_nxt;
      branch_r       <= branch_nxt;
      fade_in_done_r <= fade_in_done_nxt;
      hold_done_r    <= hold_done_nxt;
      ended_r        <= ended_nxt;
      elapsed_r      <= elapsed_nxt;
      alpha_value_r  <= alpha_value_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // shared ramp divider: elapsed is below the limit whenever it is started
  feg_div #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed_r[TIME_BITS-1:0]),
    .divisor  (limit_sel),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign out_valid    = out_valid_r;
  assign out_alpha    = out_alpha_r;
  assign out_phase    = out_phase_r;
  assign out_finished = out_finished_r;

  a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_finished_r) |-> (out_alpha_r == '0 && out_phase_r == PHASE_END))
    else $error("finished result with nonzero alpha or wrong phase");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    alpha_value_r <= ALPHA_ONE)
    else $error("alpha above full opacity");

  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WAIT) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ended_r) |-> ended_r)
    else $error("finished envelope revived");

endmodule
